// ===== rtl/core/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg: shared constants for the piecewise linear interpolator
// Widths of the Q16.16 data path, the configuration register and the
// point index port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

  // Q16.16 data words
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  // fraction of one, i.e. 1.0 in the 17-bit interpolation weight
  localparam logic [FRAC_W:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

  // point_count register and point_index port widths
  localparam int CFG_W  = 7;
  localparam int PIDX_W = 6;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // one table entry as held in the point memory
  typedef struct packed {
    logic [DATA_W-1:0]        x;
    logic signed [DATA_W-1:0] y;
  } point_t;

endpackage

`default_nettype wire

// ===== rtl/core/pli_ram.sv =====
// ----------------------------------------------------------------------------
// pli_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/piecewise_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator: Q16.16 lookup table with linear interpolation
// Table of (x, y) points in a memory, binary search, bit-serial fraction
// divide and one multiply, all under a small sequencer.
// ----------------------------------------------------------------------------
// Usage
//   Input items are offered on start with in_* and taken on a rising edge
//   where start is high and busy is low. in_mode = 0 writes one point
//   (in_point_index, in_x_value, in_y_value) in that same edge and gives no
//   result; busy stays low, so writes can follow back to back.
//   in_mode = 1 queries at in_x_value; busy rises until the one result item
//   is shown on out_y_result with a one-cycle out_valid strobe.
//   cfg_wr_en/cfg_wr_data write point_count (saturated to 2..MAX_POINTS).
// Query steps: read entry 0 and clamp if x is at or below its x; else read
//   the last entry and clamp if x is at or above its x. Otherwise a binary
//   search of at most ceil(log2(count+1)) probes, each one registered
//   memory read and one compare, finds the segment; the lower and upper
//   points are read, the 16-step restoring divider forms the weight
//   unless it is 0 or 1 (query x exactly on a table x), and one multiply
//   gives the result. The next item can be taken at the edge that ends
//   the strobe.
// Reset (rst_n, synchronous): sequencer idle, point_count = 2. The point
//   memory is not cleared; every entry in use must be written first.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_interpolator
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input item channel
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_mode,
  input  wire logic [PIDX_W-1:0]        in_point_index,
  input  wire logic [DATA_W-1:0]        in_x_value,
  input  wire logic signed [DATA_W-1:0] in_y_value,
  // result channel
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_y_result,
  // configuration
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_W-1:0]         cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SAT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int WA_W  = (IDX_W > PIDX_W) ? IDX_W : PIDX_W;
  localparam int STEP_W = $clog2(FRAC_W);
  localparam int PROD_W = 2 * DATA_W - FRAC_W + 3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_CHKLAST,
    S_SRCH,
    S_PROBE,
    S_HI,
    S_SETUP,
    S_DIV,
    S_MUL,
    S_OUT
  } state_t;

  // registers
  state_t                   state_r, state_nxt;
  logic [CFG_W-1:0]         cfg_count_r, cfg_count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_y_r, out_y_nxt;
  logic [DATA_W-1:0]        xq_r, xq_nxt;
  logic [CNT_W-1:0]         n_r, n_nxt;
  logic [CNT_W-1:0]         first_r, first_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         probe_r, probe_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic [DATA_W-1:0]        xlo_r, xlo_nxt;
  logic signed [DATA_W-1:0] ylo_r, ylo_nxt;
  logic signed [DATA_W:0]   dy_r, dy_nxt;
  logic [DATA_W-1:0]        div_d_r, div_d_nxt;
  logic [DATA_W:0]          rem_r, rem_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [FRAC_W:0]          frac_r, frac_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  // memory ports
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  point_t            wr_pt;
  point_t            rd_pt;
  logic [WA_W-1:0]   wr_idx_ext;

  // helpers
  logic              accept;
  logic [SAT_W-1:0]  cnt_ext;
  logic [CNT_W-1:0]  n_sat;
  logic [CNT_W-1:0]  n_m1;
  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  idx_clamp;
  logic [DATA_W:0]   div_t;
  logic signed [FRAC_W+1:0] frac_s;
  logic signed [PROD_W-1:0] delta;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign out_valid    = out_valid_r;
  assign out_y_result = out_y_r;

  // point writes take effect at the accept edge
  assign wr_idx_ext = WA_W'(in_point_index);
  assign wr_addr    = wr_idx_ext[IDX_W-1:0];
  assign wr_en      = accept && (in_mode == MODE_WRITE) &&
                      (32'(in_point_index) < 32'(MAX_POINTS));
  assign wr_pt.x    = in_x_value;
  assign wr_pt.y    = in_y_value;

  pli_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_pt),
    .rd_addr (rd_addr),
    .rd_data (rd_pt)
  );

  // point count saturated to 2..MAX_POINTS
  always_comb begin
    cnt_ext = SAT_W'(cfg_count_r);
    if (cnt_ext < SAT_W'(2)) begin
      n_sat = CNT_W'(2);
    end else if (cnt_ext > SAT_W'(MAX_POINTS)) begin
      n_sat = CNT_W'(MAX_POINTS);
    end else begin
      n_sat = cnt_ext[CNT_W-1:0];
    end
  end

  // search helpers
  assign n_m1 = n_r - CNT_W'(1);
  assign half = count_r >> 1;

  always_comb begin
    if (first_r == '0) begin
      idx_clamp = CNT_W'(1);
    end else if (first_r > n_m1) begin
      idx_clamp = n_m1;
    end else begin
      idx_clamp = first_r;
    end
  end

  // read address per state
  always_comb begin
    logic [CNT_W-1:0] a;
    a = '0;
    unique case (state_r)
      S_LAST:  a = n_m1;
      S_SRCH:  a = (count_r != '0) ? (first_r + half) : (idx_clamp - CNT_W'(1));
      S_HI:    a = idx_r;
      default: a = '0;
    endcase
    rd_addr = a[IDX_W-1:0];
  end

  // divider step and multiplier operands
  assign div_t  = {rem_r[DATA_W-1:0], 1'b0};
  assign frac_s = $signed({1'b0, frac_r});
  assign delta  = prod_r >>> FRAC_W;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cfg_count_nxt = cfg_wr_en ? cfg_wr_data : cfg_count_r;
    out_valid_nxt = 1'b0;
    out_y_nxt     = out_y_r;
    xq_nxt        = xq_r;
    n_nxt         = n_r;
    first_nxt     = first_r;
    count_nxt     = count_r;
    probe_nxt     = probe_r;
    idx_nxt       = idx_r;
    xlo_nxt       = xlo_r;
    ylo_nxt       = ylo_r;
    dy_nxt        = dy_r;
    div_d_nxt     = div_d_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    frac_nxt      = frac_r;
    prod_nxt      = prod_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_mode == MODE_QUERY)) begin
          xq_nxt    = in_x_value;
          n_nxt     = n_sat;
          state_nxt = S_FIRST;
        end
      end
      // read of entry 0 issued
      S_FIRST: state_nxt = S_LAST;
      // entry 0 back: clamp below, else fetch the last entry
      S_LAST: begin
        if (xq_r <= rd_pt.x) begin
          out_valid_nxt = 1'b1;
          out_y_nxt     = rd_pt.y;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_CHKLAST;
        end
      end
      // last entry back: clamp above, else start the lower-bound search
      S_CHKLAST: begin
        if (xq_r >= rd_pt.x) begin
          out_valid_nxt = 1'b1;
          out_y_nxt     = rd_pt.y;
          state_nxt     = S_IDLE;
        end else begin
          first_nxt = '0;
          count_nxt = n_r;
          state_nxt = S_SRCH;
        end
      end
      // issue a probe read, or finish and fetch the lower point
      S_SRCH: begin
        if (count_r != '0) begin
          probe_nxt = first_r + half;
          state_nxt = S_PROBE;
        end else begin
          idx_nxt   = idx_clamp;
          state_nxt = S_HI;
        end
      end
      S_PROBE: begin
        if (rd_pt.x < xq_r) begin
          first_nxt = probe_r + CNT_W'(1);
          count_nxt = count_r - half - CNT_W'(1);
        end else begin
          count_nxt = half;
        end
        state_nxt = S_SRCH;
      end
      // lower point back, upper point read issued
      S_HI: begin
        xlo_nxt   = rd_pt.x;
        ylo_nxt   = rd_pt.y;
        state_nxt = S_SETUP;
      end
      // upper point back: pick the weight or set up the divide
      S_SETUP: begin
        dy_nxt = {rd_pt.y[DATA_W-1], rd_pt.y} - {ylo_r[DATA_W-1], ylo_r};
        if (xq_r <= xlo_r) begin
          frac_nxt  = '0;
          state_nxt = S_MUL;
        end else if (xq_r >= rd_pt.x) begin
          frac_nxt  = FRAC_ONE;
          state_nxt = S_MUL;
        end else begin
          rem_nxt   = {1'b0, xq_r - xlo_r};
          div_d_nxt = rd_pt.x - xlo_r;
          frac_nxt  = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      // restoring divide, one quotient bit per cycle
      S_DIV: begin
        if (div_t >= {1'b0, div_d_r}) begin
          rem_nxt  = div_t - {1'b0, div_d_r};
          frac_nxt = {frac_r[FRAC_W-1:0], 1'b1};
        end else begin
          rem_nxt  = div_t;
          frac_nxt = {frac_r[FRAC_W-1:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(FRAC_W - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = frac_s * dy_r;
        state_nxt = S_OUT;
      end
      // arithmetic shift floors the scaled product
      S_OUT: begin
        out_valid_nxt = 1'b1;
        out_y_nxt     = ylo_r + delta[DATA_W-1:0];
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    out_y_r <= out_y_nxt;
    xq_r    <= xq_nxt;
    n_r     <= n_nxt;
    first_r <= first_nxt;
    count_r <= count_nxt;
    probe_r <= probe_nxt;
    idx_r   <= idx_nxt;
    xlo_r   <= xlo_nxt;
    ylo_r   <= ylo_nxt;
    dy_r    <= dy_nxt;
    div_d_r <= div_d_nxt;
    rem_r   <= rem_nxt;
    step_r  <= step_nxt;
    frac_r  <= frac_nxt;
    prod_r  <= prod_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_count_r <= CFG_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_count_r <= cfg_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pli_checker.sv =====
// ----------------------------------------------------------------------------
// pli_checker: port-level checks for the interpolator
// Watches the item and result handshakes over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_checker
  import pli_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_mode,
  input wire logic out_valid
);

  // a result only ends a query that kept the block busy
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a query in progress");

  // a point write neither blocks the channel nor gives a result
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_WRITE)) |=> (!busy && !out_valid))
    else $error("write item raised busy or gave a result");

  // a query item always makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_QUERY)) |=> busy)
    else $error("query item accepted without going busy");

  // the block only leaves a query by delivering its result
  a_done_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("query finished without a result");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_mode   (in_mode),
  .out_valid (out_valid)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the piecewise linear interpolator
// A short stimulus table covers the clamps, the extremes of x and y and a
// table that is not increasing. Random phases follow. Each one sets
// point_count, loads the points and sends queries mixed with point rewrites.
// Each query result is checked against a predictor in the bench or a value in the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import pli_pkg::*;
();

  localparam int        N_POINTS    = 64;
  localparam int        RAND_ITEMS  = 700;
  localparam int        N_DIR       = 22;

  typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_QUERY} row_kind_t;

  // one row of the directed table; a cfg row carries its value in x
  typedef struct packed {
    row_kind_t          kind;
    logic [PIDX_W-1:0]  pidx;
    logic [DATA_W-1:0]  x;
    logic [DATA_W-1:0]  y;
    logic               lit;
    logic [DATA_W-1:0]  want;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_mode;
  logic [PIDX_W-1:0]        in_point_index;
  logic [DATA_W-1:0]        in_x_value;
  logic signed [DATA_W-1:0] in_y_value;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_y_result;
  logic                     cfg_wr_en;
  logic [CFG_W-1:0]         cfg_wr_data;

  // bench copy of the point table and of point_count
  logic [DATA_W-1:0]        pt_x [N_POINTS];
  logic signed [DATA_W-1:0] pt_y [N_POINTS];
  logic [CFG_W-1:0]         pts_reg;

  logic signed [DATA_W-1:0] y_due_q [$];

  int unsigned burst_left;
  bit          no_idle;
  int          err_cnt;
  int          n_writes;
  int          n_queries;
  int          n_checked;
  int          n_cfg;
  int          n_phases;

  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_CFG,   6'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ROW_WRITE, 6'd0,  32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ROW_WRITE, 6'd1,  32'h0003_0000, 32'h0002_0000, 1'b0, 32'h0000_0000},
    '{ROW_QUERY, 6'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_QUERY, 6'd0,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0002_0000},
    '{ROW_QUERY, 6'd0,  32'h0001_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_QUERY, 6'd0,  32'h0003_0000, 32'h0000_0000, 1'b1, 32'h0002_0000},
    '{ROW_QUERY, 6'd0,  32'h0002_0000, 32'h0000_0000, 1'b1, 32'h0001_0000},
    '{ROW_QUERY, 6'd0,  32'h0001_0001, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ROW_QUERY, 6'd0,  32'h0002_8000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ROW_WRITE, 6'd0,  32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0000_0000},
    '{ROW_WRITE, 6'd1,  32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{ROW_QUERY, 6'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000},
    '{ROW_QUERY, 6'd0,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
    '{ROW_QUERY, 6'd0,  32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ROW_QUERY, 6'd0,  32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ROW_QUERY, 6'd0,  32'hFFFF_FFFE, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ROW_WRITE, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    // three points, the middle one above the last: not increasing
    '{ROW_CFG,   6'd0,  32'h0000_0003, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ROW_WRITE, 6'd2,  32'h0005_0000, 32'hFFFD_0000, 1'b0, 32'h0000_0000},
    '{ROW_QUERY, 6'd0,  32'h0004_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ROW_QUERY, 6'd0,  32'h0005_0000, 32'h0000_0000, 1'b1, 32'hFFFD_0000}
  };

  piecewise_linear_interpolator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_point_index (in_point_index),
    .in_x_value     (in_x_value),
    .in_y_value     (in_y_value),
    .out_valid      (out_valid),
    .out_y_result   (out_y_result),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // points in use, point_count saturated to 2..N_POINTS
  function automatic int unsigned points_in_use();
    if (pts_reg < 2) return 2;
    if (pts_reg > N_POINTS) return N_POINTS;
    return pts_reg;
  endfunction

  // interpolated y at qx over the bench table
  function automatic logic signed [DATA_W-1:0] interp_y(input logic [DATA_W-1:0] qx);
    int unsigned       n;
    int unsigned       lo;
    int unsigned       span;
    int unsigned       step;
    int unsigned       probe;
    int unsigned       k;
    logic [DATA_W-1:0] xl;
    logic [DATA_W-1:0] xh;
    longint            frac;
    longint            prod;
    longint            ylo;
    longint            yhi;
    n = points_in_use();
    if (qx <= pt_x[0]) return pt_y[0];
    if (qx >= pt_x[n-1]) return pt_y[n-1];
    // lower bound: first x not below qx
    lo   = 0;
    span = n;
    while (span > 0) begin
      step  = span / 2;
      probe = lo + step;
      if (probe < n && pt_x[probe] < qx) begin
        lo   = probe + 1;
        span = span - step - 1;
      end else begin
        span = step;
      end
    end
    k = lo;
    if (k < 1) k = 1;
    if (k > n - 1) k = n - 1;
    xl  = pt_x[k-1];
    xh  = pt_x[k];
    ylo = pt_y[k-1];
    yhi = pt_y[k];
    if (qx <= xl) frac = 0;
    else if (qx >= xh) frac = longint'(FRAC_ONE);
    else frac = (longint'(qx - xl) << FRAC_W) / longint'(xh - xl);
    // arithmetic shift floors toward minus infinity
    prod = frac * (yhi - ylo);
    return DATA_W'(ylo + (prod >>> FRAC_W));
  endfunction

  // present one item, wait for it to be taken, then record the point or predict
  task automatic send_item(input logic mode, input logic [PIDX_W-1:0] pidx,
                           input logic [DATA_W-1:0] xv, input logic [DATA_W-1:0] yv,
                           input logic lit, input logic [DATA_W-1:0] lit_y);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!no_idle)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 45) : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start          <= 1'b1;
    in_mode        <= mode;
    in_point_index <= pidx;
    in_x_value     <= xv;
    in_y_value     <= yv;
    do @(posedge clk); while (busy);
    if (mode == MODE_WRITE) begin
      pt_x[pidx] = xv;
      pt_y[pidx] = yv;
      n_writes++;
    end else begin
      y_due_q.push_back(lit ? lit_y : interp_y(xv));
      n_queries++;
    end
  endtask

  // drop start and wait until every result is in
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (y_due_q.size() != 0) @(posedge clk);
  endtask

  // write point_count with the block idle
  task automatic set_points(input logic [CFG_W-1:0] v);
    drain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    pts_reg = v;
    n_cfg++;
  endtask

  // one random phase: set count, load table, then queries and rewrites
  task automatic run_phase();
    logic [CFG_W-1:0]  cnt;
    int unsigned       n;
    int unsigned       nq;
    int unsigned       j;
    int unsigned       k;
    int unsigned       step_max;
    bit                messy;
    bit                rev;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] yv;
    logic [DATA_W-1:0] qx;
    case ($urandom_range(0, 19)) inside
      0:       cnt = 7'd0;
      1:       cnt = 7'd1;
      2:       cnt = 7'd2;
      3:       cnt = 7'd64;
      4:       cnt = 7'd65;
      5:       cnt = 7'd127;
      6:       cnt = CFG_W'($urandom_range(65, 127));
      [7:8]:   cnt = CFG_W'($urandom_range(9, 64));
      default: cnt = CFG_W'($urandom_range(2, 8));
    endcase
    set_points(cnt);
    n       = points_in_use();
    no_idle = ($urandom_range(0, 3) == 0);
    messy   = ($urandom_range(0, 4) == 0);
    rev     = $urandom_range(0, 1);
    case ($urandom_range(0, 3))
      0:       step_max = 3;
      1:       step_max = 32'h0000_0100;
      2:       step_max = 32'h0001_0000;
      default: step_max = 32'hFFFF_E000 / n;
    endcase
    // load the table, increasing x unless this is a messy phase; a reversed
    // phase writes from the top index down with falling x
    cur = $urandom_range(0, 32'h1000);
    if (rev && !messy) cur = 32'hFFFF_FFFF - cur;
    for (j = 0; j < n; j++) begin
      case ($urandom_range(0, 5)) inside
        0:       yv = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        [1:2]:   yv = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        default: yv = $urandom;
      endcase
      if (messy) cur = $urandom_range(0, 7) << $urandom_range(0, 16);
      else if (j > 0 && rev) cur = cur - $urandom_range(1, step_max);
      else if (j > 0) cur = cur + $urandom_range(1, step_max);
      k = rev ? n - 1 - j : j;
      send_item(MODE_WRITE, PIDX_W'(k), cur, yv, 1'b0, '0);
    end
    // queries mixed with rewrites
    nq = $urandom_range(6, 28);
    for (j = 0; j < nq; j++) begin
      if ($urandom_range(0, 7) == 0) begin
        k = $urandom_range(0, n - 1);
        if (messy) cur = $urandom;
        else if (k > 0 && k < n - 1) cur = $urandom_range(pt_x[k+1] - 1, pt_x[k-1] + 1);
        else cur = pt_x[k];
        send_item(MODE_WRITE, PIDX_W'(k), cur, $urandom, 1'b0, '0);
      end
      if (n < N_POINTS && $urandom_range(0, 9) == 0)
        send_item(MODE_WRITE, PIDX_W'($urandom_range(n, N_POINTS - 1)), $urandom, $urandom,
                  1'b0, '0);
      k = $urandom_range(0, n - 2);
      case ($urandom_range(0, 9))
        0:       qx = $urandom;
        1:       qx = $urandom_range(0, pt_x[0]);
        2:       qx = $urandom_range(pt_x[n-1], 32'hFFFF_FFFF);
        3:       qx = pt_x[k];
        4:       qx = pt_x[k+1] + ($urandom_range(0, 1) ? 32'h1 : 32'hFFFF_FFFF);
        default: qx = $urandom_range(pt_x[k], pt_x[k+1]);
      endcase
      send_item(MODE_QUERY, PIDX_W'($urandom_range(0, 63)), qx, $urandom, 1'b0, '0);
    end
    n_phases++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (y_due_q.size() == 0) begin
        $error("y_result: expected none, got %0d", out_y_result);
        err_cnt++;
      end else begin
        if (out_y_result !== y_due_q[0]) begin
          $error("y_result: expected %0d, got %0d", y_due_q[0], out_y_result);
          err_cnt++;
        end
        void'(y_due_q.pop_front());
        n_checked++;
      end
    end
  end

  // stimulus
  initial begin
    int i;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_mode        = MODE_WRITE;
    in_point_index = '0;
    in_x_value     = '0;
    in_y_value     = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    pts_reg        = 7'd2;
    burst_left     = 0;
    no_idle        = 1'b0;
    err_cnt        = 0;
    n_writes       = 0;
    n_queries      = 0;
    n_checked      = 0;
    n_cfg          = 0;
    n_phases       = 0;
    for (i = 0; i < N_POINTS; i++) begin
      pt_x[i] = '0;
      pt_y[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (i = 0; i < N_DIR; i++) begin
      case (dir_rows[i].kind)
        ROW_CFG:   set_points(dir_rows[i].x[CFG_W-1:0]);
        ROW_WRITE: send_item(MODE_WRITE, dir_rows[i].pidx, dir_rows[i].x, dir_rows[i].y,
                             1'b0, '0);
        default:   send_item(MODE_QUERY, dir_rows[i].pidx, dir_rows[i].x, $urandom,
                             dir_rows[i].lit, dir_rows[i].want);
      endcase
    end

    // random phases
    while (n_writes + n_queries < N_DIR + RAND_ITEMS) run_phase();

    drain();
    repeat (60) @(posedge clk);
    $display("run: %0d point writes, %0d queries (%0d checked)", n_writes, n_queries,
             n_checked);
    $display("run: %0d random phases, %0d point_count settings", n_phases, n_cfg);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
